@@ rtl/wsnr_pkg.sv @@
// shared types, constants and character classification for the word splitter
package wsnr_pkg;

    localparam int DEF_MAX_WORD_LENGTH = 255;
    localparam int DEF_VALUE_BITS      = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int LEN_W    = 8;
    localparam int INDEX_W  = 12;
    localparam int OUT_VALUE_W = 64;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;
    localparam logic [RADIX_W-1:0] BASE_RESET = 6'd10;

    localparam logic [RADIX_W-1:0] NO_DIGIT = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    typedef struct packed {
        logic [RADIX_W-1:0] digit;
        logic               blank;
        logic               sign;
        logic               minus;
        logic               zero;
        logic               x;
        logic               dot;
    } t_char_class;

    typedef struct packed {
        logic               start;
        logic               feed;
        logic               emit;
        logic               emit_valid;
        logic               emit_end;
        t_char_class        cls;
        logic [RADIX_W-1:0] radix;
        logic [INDEX_W-1:0] index;
    } t_cmd;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class r;
        r.digit = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.digit = RADIX_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            r.digit = RADIX_W'(c - CH_LO_A) + RADIX_DEC;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r.digit = RADIX_W'(c - CH_UP_A) + RADIX_DEC;
        end
        r.blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        r.sign  = (c == CH_PLUS) || (c == CH_MINUS);
        r.minus = (c == CH_MINUS);
        r.zero  = (c == CH_ZERO);
        r.x     = (c == CH_LO_X) || (c == CH_UP_X);
        r.dot   = (c == CH_DOT);
        return r;
    endfunction

endpackage

@@ rtl/wsnr_front.sv @@
// front end: quote and word tracking, character classification, command issue
module wsnr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [wsnr_pkg::CHAR_W-1:0]  i_char,
    input  logic                         i_last,
    input  logic [wsnr_pkg::RADIX_W-1:0] i_base,
    input  logic                         i_q_ready,
    output logic                         o_ready,
    output logic                         o_push,
    output wsnr_pkg::t_cmd               o_cmd
);
    import wsnr_pkg::*;

    logic               r_quotes;
    logic               r_in_word;
    logic [INDEX_W-1:0] r_count;
    logic               n_quotes;
    logic               n_in_word;
    logic [INDEX_W-1:0] n_count;

    logic accept;
    logic delim;
    logic quotes_now;
    logic start;
    logic feed;
    logic emit;
    logic emit_valid;
    logic word_after;

    assign accept = i_valid && i_q_ready;
    assign o_ready = i_q_ready;
    assign delim = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                   (i_char == CH_LF) || (i_char == CH_CR);
    assign quotes_now = r_quotes ^ (i_char == CH_QUOTE);

    always_comb begin
        start      = 1'b0;
        feed       = 1'b0;
        emit       = 1'b0;
        emit_valid = 1'b0;
        word_after = r_in_word;
        if (quotes_now) begin
            feed = r_in_word;
        end else if (r_in_word) begin
            if (delim) begin
                emit       = 1'b1;
                emit_valid = 1'b1;
                word_after = 1'b0;
            end else begin
                feed = 1'b1;
            end
        end else if (!delim) begin
            start      = 1'b1;
            feed       = 1'b1;
            word_after = 1'b1;
        end
        // end of text always yields a result, closing any open word
        if (i_last && !emit) begin
            emit       = 1'b1;
            emit_valid = word_after;
        end
    end

    always_comb begin
        o_cmd.start      = start;
        o_cmd.feed       = feed;
        o_cmd.emit       = emit;
        o_cmd.emit_valid = emit_valid;
        o_cmd.emit_end   = i_last;
        o_cmd.cls        = classify(i_char);
        o_cmd.radix      = i_base;
        o_cmd.index      = emit_valid ? r_count : '0;
    end

    assign o_push = accept && (feed || emit);

    always_comb begin
        n_quotes  = r_quotes;
        n_in_word = r_in_word;
        n_count   = r_count;
        if (accept) begin
            if (i_last) begin
                n_quotes  = 1'b0;
                n_in_word = 1'b0;
                n_count   = '0;
            end else begin
                n_quotes  = quotes_now;
                n_in_word = word_after;
                n_count   = emit_valid ? r_count + 1'b1 : r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quotes  <= 1'b0;
            r_in_word <= 1'b0;
            r_count   <= '0;
        end else begin
            r_quotes  <= n_quotes;
            r_in_word <= n_in_word;
            r_count   <= n_count;
        end
    end

endmodule

@@ rtl/wsnr_queue.sv @@
// short command queue between front and back
module wsnr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsnr_pkg::t_cmd i_cmd,
    output logic           o_not_full,
    output logic           o_valid,
    input  logic           i_pop,
    output wsnr_pkg::t_cmd o_cmd
);
    import wsnr_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;

    logic do_push;
    logic do_pop;

    assign o_not_full = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;
    assign o_cmd      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/wsnr_back.sv @@
// back end: number parse with saturating multiply-add, result staging and output register
module wsnr_back #(
    parameter int MAX_WORD_LENGTH = wsnr_pkg::DEF_MAX_WORD_LENGTH,
    parameter int VALUE_BITS      = wsnr_pkg::DEF_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  wsnr_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_word_valid,
    output logic                             o_is_number,
    output logic [wsnr_pkg::OUT_VALUE_W-1:0] o_number_value,
    output logic [wsnr_pkg::LEN_W-1:0]       o_word_length,
    output logic [wsnr_pkg::INDEX_W-1:0]     o_word_index,
    output logic                             o_end_of_text
);
    import wsnr_pkg::*;

    localparam int LW = $clog2(MAX_WORD_LENGTH + 1);
    localparam int PW = VALUE_BITS + RADIX_W;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_XPREF  = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_FAIL   = 3'd5;

    // parse state
    logic [VALUE_BITS-1:0] r_acc;
    logic [2:0]            r_phase;
    logic                  r_neg;
    logic [RADIX_W-1:0]    r_rad;
    logic                  r_ovf;
    logic                  r_dot;
    logic [LW-1:0]         r_len;
    logic [VALUE_BITS-1:0] n_acc;
    logic [2:0]            n_phase;
    logic                  n_neg;
    logic [RADIX_W-1:0]    n_rad;
    logic                  n_ovf;
    logic                  n_dot;
    logic [LW-1:0]         n_len;

    // state after an optional word start
    logic [VALUE_BITS-1:0] b_acc;
    logic [2:0]            b_phase;
    logic                  b_neg;
    logic [RADIX_W-1:0]    b_rad;
    logic                  b_ovf;
    logic                  b_dot;
    logic [LW-1:0]         b_len;

    // staged result
    logic                  r_snap_valid;
    logic                  r_snap_word;
    logic                  r_snap_num;
    logic                  r_snap_neg;
    logic [VALUE_BITS-1:0] r_snap_acc;
    logic [LEN_W-1:0]      r_snap_len;
    logic [INDEX_W-1:0]    r_snap_index;
    logic                  r_snap_end;

    // output register
    logic                   r_out_valid;
    logic                   r_out_word;
    logic                   r_out_num;
    logic [OUT_VALUE_W-1:0] r_out_value;
    logic [LEN_W-1:0]       r_out_len;
    logic [INDEX_W-1:0]     r_out_index;
    logic                   r_out_end;

    logic out_free;
    logic snap_free;
    logic fire;
    logic snap_move;

    logic [RADIX_W-1:0] mul_rad;
    logic [PW-1:0]      product;
    logic [PW-1:0]      half;
    logic [PW-1:0]      limit;
    logic [VALUE_BITS-1:0] acc_step;
    logic                  ovf_step;
    logic [RADIX_W-1:0]    first_rad;
    logic                  first_bad;
    logic                  first_zero;
    logic signed [VALUE_BITS-1:0] signed_val;
    logic [RADIX_W-1:0]    d;

    assign out_free  = !r_out_valid || i_ready;
    assign snap_free = !r_snap_valid || out_free;
    assign fire      = i_valid && (!i_cmd.emit || snap_free);
    assign snap_move = r_snap_valid && out_free;
    assign o_pop     = fire;
    assign d         = i_cmd.cls.digit;

    always_comb begin
        b_acc   = r_acc;
        b_phase = r_phase;
        b_neg   = r_neg;
        b_rad   = r_rad;
        b_ovf   = r_ovf;
        b_dot   = r_dot;
        b_len   = r_len;
        if (i_cmd.start) begin
            b_acc   = '0;
            b_phase = PH_LEAD;
            b_neg   = 1'b0;
            b_rad   = i_cmd.radix;
            b_ovf   = 1'b0;
            b_dot   = 1'b0;
            b_len   = '0;
        end
    end

    // acc * radix + digit, overflow when above the signed limit
    always_comb begin
        mul_rad  = (b_phase == PH_XPREF) ? RADIX_HEX : b_rad;
        product  = PW'(b_acc) * PW'(mul_rad) + PW'(d);
        half     = PW'(1) << (VALUE_BITS - 1);
        limit    = b_neg ? half : half - 1'b1;
        acc_step = b_acc;
        ovf_step = b_ovf;
        if (!b_ovf) begin
            if (product > limit) begin
                ovf_step = 1'b1;
                acc_step = limit[VALUE_BITS-1:0];
            end else begin
                acc_step = product[VALUE_BITS-1:0];
            end
        end
    end

    // first digit after leading blanks and sign
    always_comb begin
        first_bad  = (b_rad == RADIX_ONE) || (b_rad > RADIX_MAX);
        first_zero = ((b_rad == RADIX_AUTO) || (b_rad == RADIX_HEX)) && i_cmd.cls.zero;
        first_rad  = (b_rad == RADIX_AUTO) ? RADIX_DEC : b_rad;
        if (first_zero) begin
            first_rad = (b_rad == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
        end
    end

    always_comb begin
        n_acc   = b_acc;
        n_phase = b_phase;
        n_neg   = b_neg;
        n_rad   = b_rad;
        n_ovf   = b_ovf;
        n_dot   = b_dot;
        n_len   = b_len;
        if (i_cmd.feed) begin
            if (b_len < LW'(MAX_WORD_LENGTH)) begin
                n_len = b_len + 1'b1;
            end
            unique case (b_phase)
                PH_LEAD, PH_SIGNED: begin
                    if (b_phase == PH_LEAD && i_cmd.cls.blank) begin
                        n_phase = PH_LEAD;
                    end else if (b_phase == PH_LEAD && i_cmd.cls.sign) begin
                        n_neg   = i_cmd.cls.minus;
                        n_phase = PH_SIGNED;
                    end else if (first_bad) begin
                        n_phase = PH_FAIL;
                    end else if (first_zero) begin
                        n_rad   = first_rad;
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else begin
                        n_rad = first_rad;
                        if (d < first_rad) begin
                            n_acc   = VALUE_BITS'(d);
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_FAIL;
                        end
                    end
                end
                PH_ZERO: begin
                    if (i_cmd.cls.x) begin
                        n_phase = PH_XPREF;
                    end else if (i_cmd.cls.dot) begin
                        n_dot   = 1'b1;
                        n_phase = PH_DIGITS;
                    end else if (d < b_rad) begin
                        n_acc   = acc_step;
                        n_ovf   = ovf_step;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_XPREF: begin
                    n_rad = RADIX_HEX;
                    if (d < RADIX_HEX) begin
                        n_acc   = acc_step;
                        n_ovf   = ovf_step;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                PH_DIGITS: begin
                    if (b_dot) begin
                        n_phase = PH_FAIL;
                    end else if (i_cmd.cls.dot) begin
                        n_dot = 1'b1;
                    end else if (d < b_rad) begin
                        n_acc = acc_step;
                        n_ovf = ovf_step;
                    end else begin
                        n_phase = PH_FAIL;
                    end
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_rad   <= '0;
            r_ovf   <= 1'b0;
            r_dot   <= 1'b0;
            r_len   <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_rad   <= n_rad;
            r_ovf   <= n_ovf;
            r_dot   <= n_dot;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (fire && i_cmd.emit) begin
            r_snap_valid <= 1'b1;
        end else if (snap_move) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_cmd.emit) begin
            r_snap_word  <= i_cmd.emit_valid;
            r_snap_num   <= i_cmd.emit_valid &&
                            ((n_phase == PH_ZERO) || (n_phase == PH_DIGITS));
            r_snap_neg   <= n_neg;
            r_snap_acc   <= n_acc;
            r_snap_len   <= i_cmd.emit_valid ? LEN_W'(n_len) : '0;
            r_snap_index <= i_cmd.index;
            r_snap_end   <= i_cmd.emit_end;
        end
    end

    assign signed_val = r_snap_neg ? -signed'(r_snap_acc) : signed'(r_snap_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_out_word  <= r_snap_word;
            r_out_num   <= r_snap_num;
            r_out_value <= r_snap_num ? OUT_VALUE_W'(signed_val) : '0;
            r_out_len   <= r_snap_len;
            r_out_index <= r_snap_index;
            r_out_end   <= r_snap_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_word_valid   = r_out_word;
    assign o_is_number    = r_out_num;
    assign o_number_value = r_out_value;
    assign o_word_length  = r_out_len;
    assign o_word_index   = r_out_index;
    assign o_end_of_text  = r_out_end;

endmodule

@@ rtl/word_splitter_number_recognizer.sv @@
// Word splitter with number recognition. Text bytes enter on the slave stream,
// one transaction per byte, s_tlast on the final byte. Words are split at space,
// tab, CR and LF; a double quote toggles a quoted mode in which bytes stay in the
// current word. Each finished word gives one result transaction with its length,
// ordinal and, if it parses by strtoll rules in the number_base register, its
// value (saturated). The final byte always gives a result. One byte is taken per
// clock cycle while the command queue is not full; a result passes through the
// queue, a staging register and an output register. The rate is set by the
// combinational saturating multiply-add in the back end, fed from a four-entry queue
// so front and back stall independently. number_base is sampled when a word starts.
module word_splitter_number_recognizer #(
    parameter int MAX_WORD_LENGTH = wsnr_pkg::DEF_MAX_WORD_LENGTH,
    parameter int VALUE_BITS      = wsnr_pkg::DEF_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wsnr_pkg::CHAR_W-1:0]      s_tdata,  // [7:0] character
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [63:0] number_value, [71:64] word_length, [83:72] word_index, [87:84] zero
    output logic [wsnr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [wsnr_pkg::OUT_TUSER_W-1:0] m_tuser,  // [0] word_valid, [1] is_number
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wsnr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wsnr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wsnr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import wsnr_pkg::*;

    logic [RADIX_W-1:0] r_number_base;
    logic               reg_hit;
    logic               cfg_write;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic queue_not_full;
    logic queue_valid;
    logic back_pop;

    logic                   word_valid;
    logic                   is_number;
    logic [OUT_VALUE_W-1:0] number_value;
    logic [LEN_W-1:0]       word_length;
    logic [INDEX_W-1:0]     word_index;

    assign pready    = 1'b1;
    assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_NUMBER_BASE);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? APB_DATA_W'(r_number_base) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (cfg_write) begin
            r_number_base <= pwdata[RADIX_W-1:0];
        end
    end

    wsnr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .i_char    (s_tdata),
        .i_last    (s_tlast),
        .i_base    (r_number_base),
        .i_q_ready (queue_not_full),
        .o_ready   (s_tready),
        .o_push    (front_push),
        .o_cmd     (front_cmd)
    );

    wsnr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_push),
        .i_cmd      (front_cmd),
        .o_not_full (queue_not_full),
        .o_valid    (queue_valid),
        .i_pop      (back_pop),
        .o_cmd      (queue_cmd)
    );

    wsnr_back #(
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
        .VALUE_BITS      (VALUE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (queue_valid),
        .i_cmd          (queue_cmd),
        .o_pop          (back_pop),
        .o_valid        (m_tvalid),
        .i_ready        (m_tready),
        .o_word_valid   (word_valid),
        .o_is_number    (is_number),
        .o_number_value (number_value),
        .o_word_length  (word_length),
        .o_word_index   (word_index),
        .o_end_of_text  (m_tlast)
    );

    assign m_tdata = {4'b0000, word_index, word_length, number_value};
    assign m_tuser = {is_number, word_valid};

endmodule
